// ===== rtl/core/sorted_table_range_delete_defines.svh =====
// Assertion macros for the sorted table block.
`ifndef SORTED_TABLE_RANGE_DELETE_DEFINES_SVH
`define SORTED_TABLE_RANGE_DELETE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SRTD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define SRTD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/srtd_pkg.sv =====
package srtd_pkg;

  localparam int CAPACITY = 128;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int DATA_W   = 32;
  localparam int POS_W    = 7;
  localparam int CNTF_W   = 8;
  localparam int IN_W     = 104;
  localparam int OUT_W    = 48;

  typedef enum logic [1:0] {
    ACT_APPEND = 2'd0,
    ACT_DELETE = 2'd1,
    ACT_READ   = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_BOUNDS = 2'd2
  } status_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] value;
    logic [CNTF_W-1:0] count;
    status_t           status;
  } result_t;

endpackage

// ===== rtl/core/srtd_ram.sv =====
module srtd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/srtd_ctrl.sv =====
module srtd_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_ready,
  input  srtd_pkg::action_t                 action,
  input  logic signed [srtd_pkg::DATA_W-1:0] value,
  input  logic signed [srtd_pkg::DATA_W-1:0] range_low,
  input  logic signed [srtd_pkg::DATA_W-1:0] range_high,
  input  logic [srtd_pkg::POS_W-1:0]        position,
  output srtd_pkg::mem_req_t                mem_req,
  input  logic [srtd_pkg::DATA_W-1:0]       mem_rdata,
  input  logic                              out_free,
  output logic                              res_valid,
  output srtd_pkg::result_t                 result
);
  import srtd_pkg::*;

  typedef enum logic [1:0] {IDLE, SCAN, RDWAIT, DONE} state_t;

  state_t                    state;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          idx;
  logic [CNT_W-1:0]          kept;
  logic signed [DATA_W-1:0]  lo;
  logic signed [DATA_W-1:0]  hi;
  logic [DATA_W-1:0]         res_value;
  status_t                   res_status;

  logic                      accept;
  logic                      keep;
  logic                      last;
  logic [CNT_W-1:0]          idx_next;
  logic signed [DATA_W-1:0]  rd_s;

  assign accept    = req_valid && req_ready;
  assign req_ready = (state == IDLE);
  assign rd_s      = $signed(mem_rdata);
  assign keep      = (rd_s < lo) || (rd_s > hi);
  assign idx_next  = idx + CNT_W'(1);
  assign last      = (idx_next >= count);
  assign res_valid = (state == DONE) && out_free;

  assign result.value  = res_value;
  assign result.count  = CNTF_W'(count);
  assign result.status = res_status;

  always_comb begin
    mem_req       = '0;
    mem_req.wdata = mem_rdata;
    mem_req.waddr = kept[ADDR_W-1:0];
    mem_req.raddr = idx_next[ADDR_W-1:0];
    unique case (state)
      IDLE: begin
        if (accept) begin
          unique case (action)
            ACT_APPEND: begin
              mem_req.we    = (count != CNT_W'(CAPACITY));
              mem_req.waddr = count[ADDR_W-1:0];
              mem_req.wdata = value;
            end
            ACT_DELETE: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = '0;
            end
            ACT_READ: begin
              mem_req.re    = 1'b1;
              mem_req.raddr = ADDR_W'(position);
            end
            default: ;
          endcase
        end
      end
      SCAN: begin
        mem_req.we = keep;
        mem_req.re = !last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= IDLE;
      count      <= '0;
      idx        <= '0;
      kept       <= '0;
      res_value  <= '0;
      res_status <= ST_OK;
    end else begin
      unique case (state)
        IDLE: begin
          if (accept) begin
            res_value  <= '0;
            res_status <= ST_OK;
            lo         <= range_low;
            hi         <= range_high;
            idx        <= '0;
            kept       <= '0;
            state      <= DONE;
            unique case (action)
              ACT_APPEND: begin
                if (count == CNT_W'(CAPACITY)) begin
                  res_status <= ST_BOUNDS;
                end else begin
                  count <= count + CNT_W'(1);
                end
              end
              ACT_DELETE: begin
                if (!(range_low < range_high) || count == '0) begin
                  res_status <= ST_RANGE;
                end else begin
                  state <= SCAN;
                end
              end
              ACT_READ: begin
                if (CNT_W'(position) >= count) begin
                  res_status <= ST_BOUNDS;
                end else begin
                  state <= RDWAIT;
                end
              end
              default: ;
            endcase
          end
        end
        SCAN: begin
          if (last) begin
            count <= kept + CNT_W'(keep);
            state <= DONE;
          end else begin
            kept <= kept + CNT_W'(keep);
            idx  <= idx_next;
          end
        end
        RDWAIT: begin
          res_value <= mem_rdata;
          state     <= DONE;
        end
        DONE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/sorted_table_range_delete.sv =====
// Table of up to 128 signed 32-bit entries, filled by append and thinned by
// inclusive range delete, which keeps the order of the survivors; read gives
// one entry and the count. Every item gives exactly one result. Append, unused
// actions, a failing delete and a read past the end go from idle straight to
// the result; a good read first waits for its memory read, and a good delete
// scans every entry, reading and writing back one entry a cycle through the
// single table memory. One item is worked on at a time; the next is taken
// while a finished result waits in the output register. The table memory needs
// no clearing after reset.
module sorted_table_range_delete (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [srtd_pkg::IN_W-1:0]     s_tdata,  // value, range_low, range_high, position
  input  logic [1:0]                    s_tuser,  // action
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [srtd_pkg::OUT_W-1:0]    m_tdata   // entry_value, entry_count, status
);
  import srtd_pkg::*;

  mem_req_t          mem_req;
  logic [DATA_W-1:0] mem_rdata;
  logic              out_free;
  logic              res_valid;
  result_t           result;
  result_t           out_reg;

  assign out_free = !m_tvalid || m_tready;

  srtd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (s_tvalid),
    .req_ready  (s_tready),
    .action     (action_t'(s_tuser)),
    .value      ($signed(s_tdata[31:0])),
    .range_low  ($signed(s_tdata[63:32])),
    .range_high ($signed(s_tdata[95:64])),
    .position   (s_tdata[102:96]),
    .mem_req    (mem_req),
    .mem_rdata  (mem_rdata),
    .out_free   (out_free),
    .res_valid  (res_valid),
    .result     (result)
  );

  srtd_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_req.we),
    .waddr (mem_req.waddr),
    .wdata (mem_req.wdata),
    .re    (mem_req.re),
    .raddr (mem_req.raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {6'd0, out_reg.status, out_reg.count, out_reg.value};

endmodule

// ===== rtl/core/srtd_checker.sv =====
`include "sorted_table_range_delete_defines.svh"

module srtd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [srtd_pkg::OUT_W-1:0] m_tdata
);
  import srtd_pkg::*;

  `SRTD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
  `SRTD_ASSERT_NOW(a_count_cap, m_tvalid, m_tdata[39:32] <= CNTF_W'(CAPACITY), "count too big")
  `SRTD_ASSERT_NOW(a_status_code, m_tvalid, m_tdata[41:40] != 2'd3, "bad status")
  `SRTD_ASSERT_NOW(a_err_zero, m_tvalid && m_tdata[41:40] != 2'd0, m_tdata[31:0] == '0, "error value")
  `SRTD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid, "result dropped")

endmodule

bind sorted_table_range_delete srtd_checker u_srtd_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

// ===== dv/tb_top.sv =====
module tb_top;
  import srtd_pkg::*;

  localparam logic signed [31:0] VAL_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VAL_MAX = 32'sh7fff_ffff;

  typedef struct {
    logic signed [31:0] value;
    logic [7:0]         count;
    status_t            status;
  } table_answer_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic [1:0]        s_tuser = ACT_APPEND;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;

  // mirror of the table, updated as each item is accepted
  logic signed [31:0] mirror_entries [CAPACITY];
  int                 mirror_count = 0;
  table_answer_t      pending_answers [$];
  int                 errors = 0;
  bit                 calm = 1'b0;
  int                 stall_left = 0;

  sorted_table_range_delete i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] clamp32(longint x);
    if (x > longint'(VAL_MAX)) return VAL_MAX;
    if (x < longint'(VAL_MIN)) return VAL_MIN;
    return x[31:0];
  endfunction

  function automatic table_answer_t table_answer(action_t act, logic signed [31:0] val,
                                                 logic signed [31:0] lo,
                                                 logic signed [31:0] hi, logic [6:0] pos);
    table_answer_t ans;
    int kept;
    ans.value  = '0;
    ans.status = ST_OK;
    case (act)
      ACT_APPEND: begin
        if (mirror_count >= CAPACITY) begin
          ans.status = ST_BOUNDS;
        end else begin
          mirror_entries[7'(mirror_count)] = val;
          mirror_count++;
        end
      end
      ACT_DELETE: begin
        if (!(lo < hi) || mirror_count == 0) begin
          ans.status = ST_RANGE;
        end else begin
          kept = 0;
          for (int i = 0; i < mirror_count; i++) begin
            if (mirror_entries[7'(i)] < lo || mirror_entries[7'(i)] > hi) begin
              mirror_entries[7'(kept)] = mirror_entries[7'(i)];
              kept++;
            end
          end
          mirror_count = kept;
        end
      end
      ACT_READ: begin
        if (int'(pos) >= mirror_count) ans.status = ST_BOUNDS;
        else ans.value = mirror_entries[pos];
      end
      default: ;
    endcase
    ans.count = mirror_count[7:0];
    return ans;
  endfunction

  task automatic send_request(action_t act, logic signed [31:0] val, logic signed [31:0] lo,
                              logic signed [31:0] hi, logic [6:0] pos);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= {1'b0, pos, hi, lo, val};
    do @(posedge clk); while (!s_tready);
    pending_answers.push_back(table_answer(act, val, lo, hi, pos));
  endtask

  task automatic do_append(logic signed [31:0] val);
    send_request(ACT_APPEND, val, $urandom, $urandom, 7'($urandom_range(0, 127)));
  endtask

  task automatic do_delete(logic signed [31:0] lo, logic signed [31:0] hi);
    send_request(ACT_DELETE, $urandom, lo, hi, 7'($urandom_range(0, 127)));
  endtask

  task automatic do_read(logic [6:0] pos);
    send_request(ACT_READ, $urandom, $urandom, $urandom, pos);
  endtask

  // result checker and output back-pressure
  initial begin
    table_answer_t want;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) begin
        if (pending_answers.size() == 0) begin
          $error("result with no item outstanding: %h", m_tdata);
          errors++;
        end else begin
          want = pending_answers.pop_front();
          if ($signed(m_tdata[31:0]) !== want.value) begin
            $error("entry_value: expected %0d, got %0d", want.value, $signed(m_tdata[31:0]));
            errors++;
          end
          if (m_tdata[39:32] !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, m_tdata[39:32]);
            errors++;
          end
          if (m_tdata[41:40] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tdata[41:40]);
            errors++;
          end
        end
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if (!calm && $urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
    end
  end

  task automatic test_empty_table();
    do_delete(-5, 5);
    do_read(0);
  endtask

  task automatic test_extremes();
    do_append(VAL_MIN);
    do_append(-1);
    do_append(0);
    do_append(VAL_MAX);
    do_read(0);
    do_read(3);
    do_read(4);
    do_read(127);
  endtask

  task automatic test_bad_ranges();
    do_delete(0, 0);
    do_delete(5, -5);
    do_delete(VAL_MAX, VAL_MIN);
  endtask

  task automatic test_no_match();
    do_delete(1, 100);
  endtask

  task automatic test_unused_action();
    send_request(ACT_NONE, $urandom, $urandom, $urandom, 7'($urandom_range(0, 127)));
  endtask

  task automatic test_unsorted();
    do_append(50);
    do_append(-50);
    do_delete(-60, 60);
    do_read(0);
    do_read(1);
    do_delete(VAL_MIN, VAL_MAX);
  endtask

  task automatic test_table_full();
    longint v;
    do_delete(VAL_MIN, VAL_MAX);
    v = longint'(VAL_MIN) + $urandom_range(0, 1 << 24);
    repeat (CAPACITY) begin
      do_append(clamp32(v));
      v += $urandom_range(1, 1 << 24);
    end
    do_append($urandom);
    do_read(7'(CAPACITY - 1));
    do_read(0);
    do_delete(mirror_entries[40], mirror_entries[80]);
    do_delete(VAL_MIN, VAL_MAX);
  endtask

  task automatic test_random();
    int append_pct [6] = '{70, 40, 85, 30, 60, 90};
    int r;
    int k;
    int i;
    int j;
    longint a;
    longint b;
    longint t;
    for (int ph = 0; ph < 6; ph++) begin
      calm = (ph == 2 || ph == 5);
      repeat (100) begin
        r = $urandom_range(0, 99);
        if (r < append_pct[ph]) begin
          if ($urandom_range(0, 4) == 0 || mirror_count == 0)
            do_append($urandom);
          else
            do_append(clamp32(longint'(mirror_entries[7'(mirror_count-1)]) +
                              $urandom_range(0, 1000)));
        end else if (r < append_pct[ph] + (100 - append_pct[ph]) / 2) begin
          k = $urandom_range(0, 99);
          if (k < 50 && mirror_count > 0) begin
            i = $urandom_range(0, mirror_count - 1);
            j = $urandom_range(0, mirror_count - 1);
            a = mirror_entries[7'(i)];
            b = mirror_entries[7'(j)];
            if (a > b) begin
              t = a;
              a = b;
              b = t;
            end
            a -= $urandom_range(0, 2);
            b += $urandom_range(0, 2);
            if (a >= b) b = a + 1;
            if (b > longint'(VAL_MAX)) begin
              b = VAL_MAX;
              a = b - 1;
            end
            do_delete(clamp32(a), clamp32(b));
          end else if (k < 65) begin
            do_delete($urandom, $urandom);
          end else if (k < 75) begin
            a = $signed(32'($urandom));
            do_delete(a[31:0], clamp32(a - $urandom_range(0, 5)));
          end else if (k < 80) begin
            do_delete(VAL_MIN, VAL_MAX);
          end else begin
            a = $signed(32'($urandom));
            do_delete(a[31:0], clamp32(a + $urandom_range(1, 100)));
          end
        end else if ($urandom_range(0, 19) == 0) begin
          test_unused_action();
        end else if (mirror_count > 0 && $urandom_range(0, 99) < 85) begin
          do_read(7'($urandom_range(0, mirror_count - 1)));
        end else begin
          do_read(7'($urandom_range(0, 127)));
        end
      end
    end
    calm = 1'b0;
  endtask

  initial begin
    int waited;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_extremes();
    test_bad_ranges();
    test_no_match();
    test_unused_action();
    test_unsorted();
    test_table_full();
    test_random();

    s_tvalid <= 1'b0;
    waited = 0;
    while (pending_answers.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (16) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $error("%0d results never arrived", pending_answers.size());
      errors++;
    end

    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
